// ===== rtl/esc_pkg.sv =====
package esc_pkg;

   localparam int SPEED_FRAC_BITS       = 8;
   localparam int INDUCTANCE_KV_PRODUCT = 2;

   // Shift amounts of the fixed-point chain; all but Q_SHIFT are derived from the speed format.
   localparam logic [6:0] Q_SHIFT    = 7'd16;
   localparam logic [6:0] LOAD_SHIFT = 7'(2 * SPEED_FRAC_BITS);
   localparam logic [6:0] EMF_SHIFT  = 7'(48 - SPEED_FRAC_BITS);
   localparam logic [6:0] NUM_SHIFT  = 7'(16 + 2 * SPEED_FRAC_BITS);

   localparam logic [63:0] C1_FACTOR        = 64'(2000000 * INDUCTANCE_KV_PRODUCT);
   localparam logic [63:0] STANDSTILL_LIMIT = 64'd1 << SPEED_FRAC_BITS;
   localparam logic [63:0] MILLI_SCALE      = 64'd1000;
   localparam logic [63:0] MAG_CAP          = 64'h8000_0000_0000_0000;

   // The applied voltage numerator is below 2^48, so ceil(2^58 / 1000) followed by
   // a right shift of 58 gives the exact quotient by 1000.
   localparam logic [63:0] EA_RECIP = 64'd288230376151712;
   localparam logic [6:0]  EA_SHIFT = 7'd58;

   localparam logic [15:0]        MIN_MILLIVOLTS = 16'd3000;
   localparam logic signed [17:0] CMD_LOW        = -18'sd65;
   localparam logic signed [17:0] CMD_HIGH       = 18'sd65601;
   localparam logic signed [17:0] CMD_FULL       = 18'sd65536;
   localparam logic [16:0]        THR_FULL       = 17'd65536;
   localparam logic [30:0]        SPEED_CAP      = 31'h7FFF_FFFF;

   localparam logic [31:0] KV_RESET    = 32'd65536000;
   localparam logic [31:0] RES_RESET   = 32'd6554;
   localparam logic [31:0] KF_RESET    = 32'd1;
   localparam logic [31:0] KM_RESET    = 32'd1311;
   localparam logic [31:0] ILIM_RESET  = 32'd2621440;
   localparam logic [15:0] DT_RESET    = 16'd1000;
   localparam logic [15:0] TMO_RESET   = 16'd500;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_THROTTLE,
      OP_BREAK,
      OP_UNUSED
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_KV,
      CSR_RES,
      CSR_KF,
      CSR_KM,
      CSR_CW,
      CSR_ILIM,
      CSR_DT,
      CSR_TMO
   } csr_index_type;

   typedef enum logic [1:0] {
      STAT_INTACT,
      STAT_BROKEN,
      STAT_SKIPPED
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ,
      ST_TQ,
      ST_QQ,
      ST_CU,
      ST_TICK_CHK,
      ST_EA_MUL,
      ST_EA_DIV,
      ST_DROP,
      ST_EMF,
      ST_CMP,
      ST_POST,
      ST_PK,
      ST_MS,
      ST_C1,
      ST_DEN,
      ST_DW,
      ST_DONE,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      PH_TICK,
      PH_EQ,
      PH_CUR
   } phase_type;

   // Shift right and clamp to 64 bits.
   function automatic logic [63:0] sat_shr(input logic [127:0] p, input logic [6:0] s);
      logic [127:0] t;
      t = p >> s;
      return (|t[127:64]) ? '1 : t[63:0];
   endfunction

endpackage

// ===== rtl/esc_motor_speed_emulator.sv =====
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid / req_tready  tdata: command, battery; tuser: opcode
// rsp_      out        rsp_tvalid / rsp_tready  tdata: speed, thrust, current, flags
// csr_      in         csr_we                   csr_addr selects, csr_wdata carries value
//
// Any item other than a tick with battery data goes straight to the output stage.
// A tick with battery data runs 31 trial speeds for the equilibrium search, each one
// 128-step pass of the shared divider plus five 64x64 products on the shared
// four-pass multiplier, followed by one Euler step that uses both units again, unless
// the rotor is at standstill, already at equilibrium or km*kf is zero.
// Reset is synchronous; it restores the register defaults and the rotor state.
// A finished result waits in the output register; the next item is taken meanwhile.
module esc_motor_speed_emulator
   import esc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [17:0] throttle_cmd, [18] battery_valid, [34:19] battery_millivolts
   input  logic [39:0]  req_tdata,
   // [1:0] opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] rotor_speed, [63:32] thrust, [95:64] motor_current,
   // [97:96] rotor_status, [98] throttle_range_error, [99] command_accepted
   output logic [103:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      issued_ff, issued_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [103:0] rsp_data_ff, rsp_data_in;

   logic [31:0] kv_ff, res_ff, kf_ff, km_ff, ilim_ff;
   logic        cw_ff;
   logic [15:0] dt_ff, tmo_ff;

   logic [16:0]        thr_ff, thr_in;
   logic signed [31:0] speed_ff, speed_in;
   logic [15:0]        ticks_ff, ticks_in;
   logic               intact_ff, intact_in;

   logic [15:0]  mv_ff, mv_in;
   logic [31:0]  w_ff, w_in;
   logic [63:0]  x_ff, x_in, t_ff, t_in, cu_ff, cu_in, drop_ff, drop_in;
   logic [63:0]  ea_ff, ea_in, pk_ff, pk_in, mag_ff, mag_in;
   logic [30:0]  eq_ff, eq_in, cur_ff, cur_in, next_ff, next_in;
   logic [4:0]   bit_ff, bit_in;
   logic [127:0] num_ff, num_in, den_ff, den_in;
   logic [31:0]  res_thrust_ff, res_thrust_in, res_cur_ff, res_cur_in;
   logic         res_err_ff, res_err_in, res_acc_ff, res_acc_in, res_skip_ff, res_skip_in;

   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_p;
   logic         div_start, div_done;
   logic [127:0] div_n, div_d;
   logic [63:0]  div_q;

   opcode_type         op;
   logic signed [17:0] cmd;
   logic               bat;
   logic [15:0]        mv;
   logic [15:0]        ticks_inc;
   logic [31:0]        speed_mag;
   logic               emf_special;
   logic [63:0]        emf_val, need_val;
   logic [64:0]        need_sum;
   logic               cur_below;
   logic [63:0]        gap;
   logic [30:0]        eq_new;
   logic [1:0]         status;

   assign op  = opcode_type'(req_tuser);
   assign cmd = signed'(req_tdata[17:0]);
   assign bat = req_tdata[18];
   assign mv  = req_tdata[34:19];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign ticks_inc = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;
   assign speed_mag = speed_ff[31] ? 32'd0 - 32'(speed_ff) : 32'(speed_ff);

   assign emf_special = (w_ff == 32'd0) || (kv_ff == 32'd0);
   assign emf_val     = (w_ff == 32'd0) ? 64'd0 : ((kv_ff == 32'd0) ? '1 : div_q);
   assign need_sum    = {1'b0, emf_val} + {1'b0, drop_ff};
   assign need_val    = need_sum[64] ? '1 : need_sum[63:0];

   assign cur_below = (cur_ff < eq_ff);
   assign gap       = cur_below ? 64'(eq_ff - cur_ff) : 64'(cur_ff - eq_ff);
   assign eq_new    = (x_ff <= ea_ff) ? w_ff[30:0] : eq_ff;
   assign status    = res_skip_ff ? STAT_SKIPPED : (intact_ff ? STAT_INTACT : STAT_BROKEN);

   esc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   esc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .n     (div_n),
      .d     (div_d),
      .done  (div_done),
      .q     (div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (op == OP_TICK && bat) ? ST_SQ : ST_FIN;
            end
         end
         ST_SQ:       if (mul_done) state_in = ST_TQ;
         ST_TQ:       if (mul_done) state_in = ST_QQ;
         ST_QQ:       if (mul_done) state_in = ST_CU;
         ST_CU: begin
            if (mul_done) state_in = (phase_ff == PH_TICK) ? ST_TICK_CHK : ST_DROP;
         end
         ST_TICK_CHK: state_in = ST_EA_MUL;
         ST_EA_MUL:   if (mul_done) state_in = ST_EA_DIV;
         ST_EA_DIV:   if (mul_done) state_in = ST_SQ;
         ST_DROP:     if (mul_done) state_in = ST_EMF;
         ST_EMF:      if (emf_special || div_done) state_in = ST_CMP;
         ST_CMP: begin
            if (phase_ff == PH_EQ) begin
               state_in = (bit_ff == 5'd0) ? ST_POST : ST_SQ;
            end else begin
               state_in = ST_MS;
            end
         end
         ST_POST: begin
            if ((64'(cur_ff) * MILLI_SCALE) < STANDSTILL_LIMIT || cur_ff == eq_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PK;
            end
         end
         ST_PK: begin
            if (mul_done) state_in = (mul_p[63:0] == 64'd0) ? ST_DONE : ST_SQ;
         end
         ST_MS:       if (mul_done) state_in = ST_C1;
         ST_C1:       if (mul_done) state_in = ST_DEN;
         ST_DEN:      if (mul_done) state_in = ST_DW;
         ST_DW:       if (div_done) state_in = ST_DONE;
         ST_DONE:     state_in = ST_FIN;
         ST_FIN:      if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      issued_in     = issued_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      thr_in        = thr_ff;
      speed_in      = speed_ff;
      ticks_in      = ticks_ff;
      intact_in     = intact_ff;
      mv_in         = mv_ff;
      w_in          = w_ff;
      x_in          = x_ff;
      t_in          = t_ff;
      cu_in         = cu_ff;
      drop_in       = drop_ff;
      ea_in         = ea_ff;
      pk_in         = pk_ff;
      mag_in        = mag_ff;
      eq_in         = eq_ff;
      cur_in        = cur_ff;
      next_in       = next_ff;
      bit_in        = bit_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      res_thrust_in = res_thrust_ff;
      res_cur_in    = res_cur_ff;
      res_err_in    = res_err_ff;
      res_acc_in    = res_acc_ff;
      res_skip_in   = res_skip_ff;
      mul_start     = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      div_n         = '0;
      div_d         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_thrust_in = '0;
               res_cur_in    = '0;
               res_err_in    = 1'b0;
               res_acc_in    = 1'b0;
               res_skip_in   = 1'b0;
               mv_in         = mv;
               issued_in     = 1'b0;
               case (op)
                  OP_TICK: begin
                     ticks_in = ticks_inc;
                     if (!bat) begin
                        res_skip_in = 1'b1;
                     end else begin
                        if (ticks_inc > tmo_ff) thr_in = '0;
                        w_in     = speed_mag;
                        phase_in = PH_TICK;
                     end
                  end
                  OP_THROTTLE: begin
                     if (bat && mv >= MIN_MILLIVOLTS && intact_ff) begin
                        ticks_in   = '0;
                        res_acc_in = 1'b1;
                        res_err_in = (cmd < CMD_LOW) || (cmd > CMD_HIGH);
                        if (cmd < 18'sd0) begin
                           thr_in = '0;
                        end else if (cmd > CMD_FULL) begin
                           thr_in = THR_FULL;
                        end else begin
                           thr_in = cmd[16:0];
                        end
                     end
                  end
                  OP_BREAK: begin
                     intact_in = 1'b0;
                     thr_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SQ: begin
            mul_a = {32'b0, w_ff};
            mul_b = {32'b0, w_ff};
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               x_in      = mul_p[63:0];
            end
         end
         ST_TQ: begin
            mul_a = {32'b0, kf_ff};
            mul_b = x_ff;
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               t_in      = sat_shr(mul_p, LOAD_SHIFT);
            end
         end
         ST_QQ: begin
            mul_a = {32'b0, km_ff};
            mul_b = t_ff;
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               x_in      = sat_shr(mul_p, Q_SHIFT);
            end
         end
         ST_CU: begin
            mul_a = {32'b0, kv_ff};
            mul_b = x_ff;
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               cu_in     = sat_shr(mul_p, Q_SHIFT);
            end
         end
         ST_TICK_CHK: begin
            res_thrust_in = (|t_ff[63:48]) ? '1 : t_ff[47:16];
            res_cur_in    = (|cu_ff[63:48]) ? '1 : cu_ff[47:16];
            if (cu_ff > {16'b0, ilim_ff, 16'b0}) begin
               intact_in = 1'b0;
               thr_in    = '0;
            end
            // Only motion in the configured direction counts as speed.
            if (cw_ff ? speed_ff < 32'sd0 : speed_ff > 32'sd0) begin
               cur_in = w_ff[31] ? SPEED_CAP : w_ff[30:0];
            end else begin
               cur_in = '0;
            end
         end
         ST_EA_MUL: begin
            mul_a = {48'b0, mv_ff};
            mul_b = {47'b0, thr_ff};
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               x_in      = mul_p[63:0];
            end
         end
         ST_EA_DIV: begin
            // The quotient by 1000 comes from the reciprocal product.
            mul_a = {x_ff[47:0], 16'b0};
            mul_b = EA_RECIP;
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               ea_in     = 64'(mul_p >> EA_SHIFT);
               eq_in     = '0;
               bit_in    = 5'd30;
               w_in      = 32'd1 << 30;
               phase_in  = PH_EQ;
            end
         end
         ST_DROP: begin
            mul_a = {32'b0, res_ff};
            mul_b = cu_ff;
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               drop_in   = sat_shr(mul_p, Q_SHIFT);
            end
         end
         ST_EMF: begin
            div_n = {96'b0, w_ff} << EMF_SHIFT;
            div_d = {96'b0, kv_ff};
            if (emf_special) begin
               x_in = need_val;
            end else if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               x_in      = need_val;
            end
         end
         ST_CMP: begin
            if (phase_ff == PH_EQ) begin
               eq_in = eq_new;
               if (bit_ff != 5'd0) begin
                  bit_in = bit_ff - 5'd1;
                  w_in   = {1'b0, eq_new | (31'd1 << (bit_ff - 5'd1))};
               end
            end else begin
               // Wrapping difference, as the motor equation is evaluated unsigned.
               mag_in = cur_below ? ea_ff - x_ff : x_ff - ea_ff;
               if (mag_in > MAG_CAP) mag_in = MAG_CAP;
            end
         end
         ST_POST: begin
            next_in = eq_ff;
         end
         ST_PK: begin
            mul_a = {32'b0, km_ff};
            mul_b = {32'b0, kf_ff};
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               pk_in     = mul_p[63:0];
               w_in      = {1'b0, cur_ff};
               phase_in  = PH_CUR;
            end
         end
         ST_MS: begin
            mul_a = mag_ff;
            mul_b = {48'b0, dt_ff};
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               num_in    = mul_p << NUM_SHIFT;
            end
         end
         ST_C1: begin
            mul_a = C1_FACTOR;
            mul_b = {33'b0, cur_ff};
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               x_in      = mul_p[63:0];
            end
         end
         ST_DEN: begin
            mul_a = pk_ff;
            mul_b = x_ff;
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               den_in    = mul_p;
            end
         end
         ST_DW: begin
            div_n = num_ff;
            div_d = den_ff;
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               if (div_q >= gap) begin
                  next_in = eq_ff;
               end else if (cur_below) begin
                  next_in = cur_ff + div_q[30:0];
               end else begin
                  next_in = cur_ff - div_q[30:0];
               end
            end
         end
         ST_DONE: begin
            speed_in = cw_ff ? -signed'({1'b0, next_ff}) : signed'({1'b0, next_ff});
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, res_acc_ff, res_err_ff, status, res_cur_ff,
                               res_thrust_ff, 32'(speed_ff)};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= '0;
         speed_ff     <= '0;
         ticks_ff     <= '0;
         intact_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         speed_ff     <= speed_in;
         ticks_ff     <= ticks_in;
         intact_ff    <= intact_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      rsp_data_ff   <= rsp_data_in;
      mv_ff         <= mv_in;
      w_ff          <= w_in;
      x_ff          <= x_in;
      t_ff          <= t_in;
      cu_ff         <= cu_in;
      drop_ff       <= drop_in;
      ea_ff         <= ea_in;
      pk_ff         <= pk_in;
      mag_ff        <= mag_in;
      eq_ff         <= eq_in;
      cur_ff        <= cur_in;
      next_ff       <= next_in;
      bit_ff        <= bit_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      res_thrust_ff <= res_thrust_in;
      res_cur_ff    <= res_cur_in;
      res_err_ff    <= res_err_in;
      res_acc_ff    <= res_acc_in;
      res_skip_ff   <= res_skip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kv_ff   <= KV_RESET;
         res_ff  <= RES_RESET;
         kf_ff   <= KF_RESET;
         km_ff   <= KM_RESET;
         cw_ff   <= 1'b0;
         ilim_ff <= ILIM_RESET;
         dt_ff   <= DT_RESET;
         tmo_ff  <= TMO_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_KV:   kv_ff   <= csr_wdata;
            CSR_RES:  res_ff  <= csr_wdata;
            CSR_KF:   kf_ff   <= csr_wdata;
            CSR_KM:   km_ff   <= csr_wdata;
            CSR_CW:   cw_ff   <= csr_wdata[0];
            CSR_ILIM: ilim_ff <= csr_wdata;
            CSR_DT:   dt_ff   <= csr_wdata[15:0];
            CSR_TMO:  tmo_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // A broken rotor stays broken until reset.
   a_broken_sticks: assert property (@(posedge clock) disable iff (reset)
      !intact_ff |=> !intact_ff)
      else $error("rotor came back from broken");

   a_broken_no_throttle: assert property (@(posedge clock) disable iff (reset)
      !intact_ff |-> (thr_ff == '0))
      else $error("throttle nonzero on broken rotor");

   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      thr_ff <= THR_FULL)
      else $error("throttle above full scale");

endmodule

// ===== rtl/esc_mul.sv =====
module esc_mul
   import esc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] p
);

   logic         busy_ff, busy_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         pv_ff, pv_in;
   logic         done_ff, done_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   psh_ff, psh_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  a_half, b_half;

   assign a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];

   // One 32x32 partial product per cycle, added into the sum in the following cycle.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      pv_in   = pv_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      psh_in  = psh_ff;
      acc_in  = acc_ff;
      if (start) begin
         a_in    = a;
         b_in    = b;
         cnt_in  = '0;
         acc_in  = '0;
         pv_in   = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (pv_ff) begin
            acc_in = acc_ff + ({64'b0, pp_ff} << {psh_ff, 5'b0});
         end
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            pv_in   = 1'b0;
         end else begin
            pp_in  = 64'(a_half) * 64'(b_half);
            psh_in = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            pv_in  = 1'b1;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         pv_ff   <= pv_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      psh_ff <= psh_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

// ===== rtl/esc_div.sv =====
module esc_div
   import esc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] n,
   input  logic [127:0] d,
   output logic         done,
   output logic [63:0]  q
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] n_ff, n_in, d_ff, d_in, r_ff, r_in;
   logic [63:0]  q_ff, q_in;
   logic         sat_ff, sat_in;
   logic [127:0] r_shift;
   logic [128:0] diff;
   logic         fits;

   // Restoring division, one quotient bit per cycle, from bit 127 down.
   assign r_shift = {r_ff[126:0], n_ff[127]};
   assign diff    = {1'b0, r_shift} - {1'b0, d_ff};
   assign fits    = !diff[128];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      if (start) begin
         n_in    = n;
         d_in    = d;
         r_in    = '0;
         q_in    = '0;
         sat_in  = 1'b0;
         cnt_in  = 7'd127;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = fits ? diff[127:0] : r_shift;
         q_in   = {q_ff[62:0], fits};
         sat_in = sat_ff | (fits & cnt_ff[6]);
         n_in   = {n_ff[126:0], 1'b0};
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign q    = sat_ff ? '1 : q_ff;

endmodule
